FILE: hw/rtl/b40te_pkg.sv
// b40te_pkg: shared types, symbol codes and helper functions for the base-40
// triplet encoder. It has no dependencies. The front, queue, back and top files use it.
package b40te_pkg;

  typedef logic [5:0] sym_t;

  // Symbol codes
  localparam sym_t SymNul     = 6'd0;
  localparam sym_t SymSpace   = 6'd37;
  localparam sym_t SymNewline = 6'd38;
  localparam sym_t SymShift   = 6'd39;
  localparam sym_t SymUnknown = 6'd37;
  localparam sym_t SymPad     = 6'd0;

  localparam logic [15:0] WeightFirst  = 16'd1600;
  localparam logic [15:0] WeightSecond = 16'd40;

  localparam int QueueDepthDefault = 2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } char_item_t;

  typedef struct packed {
    logic [15:0] packed_word;
    logic        run_end;
  } word_item_t;

  typedef struct packed {
    logic shifted;
    sym_t sym;
  } char_class_t;

  typedef struct packed {
    sym_t sym_a;
    sym_t sym_b;
    sym_t sym_c;
  } triplet_t;

  // One accepted character's worth of output words (one or two)
  typedef struct packed {
    logic     two;
    triplet_t first;
    triplet_t second;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Two-row table lookup: unshifted symbols, or shifted symbols sent after SymShift.
  function automatic char_class_t map_char(logic [7:0] c);
    char_class_t r;
    r.shifted = 1'b0;
    r.sym     = SymUnknown;
    unique case (c) inside
      8'h00, 8'h7E:   r.sym = SymNul;
      [8'h61:8'h7A]:  r.sym = 6'(c - 8'h60);
      [8'h30:8'h39]:  r.sym = 6'(c - 8'd21);
      8'h20:          r.sym = SymSpace;
      8'h0A:          r.sym = SymNewline;
      [8'h41:8'h5A]: begin
        r.shifted = 1'b1;
        r.sym     = 6'(c - 8'h40);
      end
      8'h28: begin r.shifted = 1'b1; r.sym = 6'd27; end
      8'h21: begin r.shifted = 1'b1; r.sym = 6'd28; end
      8'h40: begin r.shifted = 1'b1; r.sym = 6'd29; end
      8'h23: begin r.shifted = 1'b1; r.sym = 6'd30; end
      8'h2C: begin r.shifted = 1'b1; r.sym = 6'd31; end
      8'h2E: begin r.shifted = 1'b1; r.sym = 6'd32; end
      8'h3F: begin r.shifted = 1'b1; r.sym = 6'd33; end
      8'h2F: begin r.shifted = 1'b1; r.sym = 6'd34; end
      8'h2A: begin r.shifted = 1'b1; r.sym = 6'd35; end
      8'h29: begin r.shifted = 1'b1; r.sym = 6'd36; end
      8'h3C: begin r.shifted = 1'b1; r.sym = 6'd37; end
      8'h3E: begin r.shifted = 1'b1; r.sym = 6'd38; end
      default: begin
        r.shifted = 1'b0;
        r.sym     = SymUnknown;
      end
    endcase
    return r;
  endfunction

  // a*1600 + b*40 + c; the maximum is 63999, so it fits 16 bits
  function automatic logic [15:0] pack_word(triplet_t t);
    logic [15:0] a_part;
    logic [15:0] b_part;
    a_part = 16'(16'(t.sym_a) * WeightFirst);
    b_part = 16'(16'(t.sym_b) * WeightSecond);
    return 16'(a_part + b_part + 16'(t.sym_c));
  endfunction

endpackage

FILE: hw/rtl/b40te_front.sv
// b40te_front: accepts characters, classifies them and tracks the partial word.
// It emits one job per character that completes words. It depends on b40te_pkg.
module b40te_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  input  b40te_pkg::char_item_t  char_item,
  output logic                   char_stall,
  input  b40te_pkg::queue_status_t q_status,
  output logic                   push,
  output b40te_pkg::job_t        job
);

  logic [1:0]          count;
  b40te_pkg::sym_t     buf0;
  b40te_pkg::sym_t     buf1;

  logic                    accept;
  b40te_pkg::char_class_t  cls;
  logic [1:0]              count_next;
  b40te_pkg::sym_t         buf0_next;
  b40te_pkg::sym_t         buf1_next;
  logic [1:0]              nw;
  b40te_pkg::triplet_t     w0;
  b40te_pkg::triplet_t     w1;

  assign char_stall = q_status.full;
  assign accept     = char_valid && !char_stall;

  // Up to two symbol pushes, then an optional flush of a partial word.
  always_comb begin
    cls        = b40te_pkg::map_char(char_item.char_in);
    count_next = count;
    buf0_next  = buf0;
    buf1_next  = buf1;
    nw         = 2'd0;
    w0         = '0;
    w1         = '0;

    if (cls.shifted) begin
      if (count_next == 2'd2) begin
        w0         = '{buf0_next, buf1_next, b40te_pkg::SymShift};
        nw         = 2'd1;
        count_next = 2'd0;
      end else begin
        if (count_next == 2'd0) begin
          buf0_next = b40te_pkg::SymShift;
        end else begin
          buf1_next = b40te_pkg::SymShift;
        end
        count_next = count_next + 2'd1;
      end
    end

    if (count_next == 2'd2) begin
      if (nw == 2'd0) begin
        w0 = '{buf0_next, buf1_next, cls.sym};
      end else begin
        w1 = '{buf0_next, buf1_next, cls.sym};
      end
      nw         = nw + 2'd1;
      count_next = 2'd0;
    end else begin
      if (count_next == 2'd0) begin
        buf0_next = cls.sym;
      end else begin
        buf1_next = cls.sym;
      end
      count_next = count_next + 2'd1;
    end

    if (char_item.last_char && count_next != 2'd0) begin
      if (nw == 2'd0) begin
        w0 = '{buf0_next, (count_next == 2'd2) ? buf1_next : b40te_pkg::SymPad,
               b40te_pkg::SymPad};
      end else begin
        w1 = '{buf0_next, (count_next == 2'd2) ? buf1_next : b40te_pkg::SymPad,
               b40te_pkg::SymPad};
      end
      nw         = nw + 2'd1;
      count_next = 2'd0;
    end
  end

  assign push       = accept && (nw != 2'd0);
  assign job.two    = (nw == 2'd2);
  assign job.first  = w0;
  assign job.second = w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf0 <= buf0_next;
      buf1 <= buf1_next;
    end
  end

endmodule

FILE: hw/rtl/b40te_queue.sv
// b40te_queue: small FIFO of jobs between the front and back ends.
// It depends on b40te_pkg for the job and status types.
module b40te_queue #(
  parameter int Depth = b40te_pkg::QueueDepthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  b40te_pkg::job_t          push_job,
  input  logic                     pop,
  output b40te_pkg::job_t          head_job,
  output b40te_pkg::queue_status_t status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b40te_pkg::job_t   entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   fill;

  assign status.full  = (fill == FullCnt);
  assign status.empty = (fill == '0);
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: hw/rtl/b40te_back.sv
// b40te_back: drains jobs one word per cycle into the output register, unless word_stall holds it.
// It packs each triplet as a*1600 + b*40 + c. It depends on b40te_pkg.
module b40te_back (
  input  logic                     clk,
  input  logic                     rst,
  input  b40te_pkg::job_t          head_job,
  input  b40te_pkg::queue_status_t q_status,
  output logic                     pop,
  output logic                     word_valid,
  output b40te_pkg::word_item_t    word_item,
  input  logic                     word_stall
);

  logic                 phase;   // 1: second word of the head job is next
  logic                 load_ok;
  logic                 load;
  logic                 is_last;
  b40te_pkg::triplet_t  sel;

  assign load_ok = !word_valid || !word_stall;
  assign load    = load_ok && !q_status.empty;
  assign sel     = phase ? head_job.second : head_job.first;
  assign is_last = !head_job.two || phase;
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (load_ok) begin
      word_valid <= !q_status.empty;
      if (load) begin
        phase <= !is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_item.packed_word <= b40te_pkg::pack_word(sel);
      word_item.run_end     <= is_last;
    end
  end

endmodule

FILE: hw/rtl/base40_triplet_encoder_core.sv
// base40_triplet_encoder_core: top level of the base-40 triplet encoder.
// It instantiates b40te_front, b40te_queue and b40te_back and uses b40te_pkg.
//
// Takes one character byte per transfer and emits 16-bit words that each hold
// three base-40 symbols (first*1600 + second*40 + third). Lowercase letters,
// digits, space, newline and NUL (or tilde) give one symbol. Uppercase letters
// and the punctuation set ( ! @ # , . ? / * ) < > give the shift code 39
// followed by their index. Any other byte gives symbol 37. With last_char set,
// a partial word is padded with zero symbols and sent, and the next message
// starts empty. run_end marks the final word caused by a character. Characters
// that complete no word cause no transfer. Rate: one character per cycle while
// char_stall is low. A character that yields two words (a shifted character
// that closes a word and then flushes) gives the output two words to send, and
// the output register sends one word per cycle unless word_stall holds it. The
// job queue (QueueDepth entries) absorbs the difference. Between character
// transfer and first word valid, the front writes the job into the queue and
// the back then loads the output register. char_stall rises only when the
// queue is full.
module base40_triplet_encoder_core #(
  parameter int QueueDepth = b40te_pkg::QueueDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  input  b40te_pkg::char_item_t char_item,
  output logic                  char_stall,
  output logic                  word_valid,
  output b40te_pkg::word_item_t word_item,
  input  logic                  word_stall
);

  // Front to queue
  logic                     push;
  b40te_pkg::job_t          push_job;
  // Queue to back
  logic                     pop;
  b40te_pkg::job_t          head_job;
  b40te_pkg::queue_status_t q_status;

  // Classifies characters and keeps the pending symbols
  b40te_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_item  (char_item),
    .char_stall (char_stall),
    .q_status   (q_status),
    .push       (push),
    .job        (push_job)
  );

  // Decouples character intake from word output
  b40te_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  // Packs the words and holds the output register
  b40te_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .q_status   (q_status),
    .pop        (pop),
    .word_valid (word_valid),
    .word_item  (word_item),
    .word_stall (word_stall)
  );

  // The front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("job pushed into full queue");

  // The back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("job popped from empty queue");

  // A word without run_end always has its companion word right behind it
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (word_valid && !word_stall && !word_item.run_end) |=> word_valid)
    else $error("second word of a character missing");

endmodule

FILE: sim/tb_base40_triplet_encoder_core.sv
// tb_base40_triplet_encoder_core: self-checking bench for the base-40 triplet encoder.
// Depends on b40te_pkg (payload structs, symbol codes) and base40_triplet_encoder_core.
// A class mirrors the symbol buffer and keeps the queue of words still due.
module tb_base40_triplet_encoder_core;

  // Cycles with no transfer on either channel before the run is declared hung.
  localparam int unsigned QuietLimit = 2000;
  // Extra cycles after the last due word, to catch stray output words.
  localparam int unsigned TailCycles = 8;
  localparam int unsigned MismatchPrintMax = 10;

  // Mirror of the encoder: symbol buffer, word packing, flush on end of message.
  class word_predictor;
    b40te_pkg::sym_t        held [2];
    int unsigned            held_count;
    b40te_pkg::word_item_t  words_due [$];
    int unsigned            failures;

    function new();
      held_count = 0;
      failures   = 0;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= MismatchPrintMax) begin
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function logic [15:0] weigh(b40te_pkg::sym_t a, b40te_pkg::sym_t b, b40te_pkg::sym_t c);
      return 16'(int'(a) * 1600 + int'(b) * 40 + int'(c));
    endfunction

    // Table lookup; shifted symbols go out after the shift code.
    function void classify(input logic [7:0] c, output bit shifted,
                           output b40te_pkg::sym_t s);
      shifted = 1'b0;
      s       = b40te_pkg::SymUnknown;
      if (c == "~" || c == 8'h00) begin
        s = b40te_pkg::SymNul;
      end else if (c >= "a" && c <= "z") begin
        s = b40te_pkg::sym_t'(c - "a" + 1);
      end else if (c >= "0" && c <= "9") begin
        s = b40te_pkg::sym_t'(c - "0" + 27);
      end else if (c == " ") begin
        s = b40te_pkg::SymSpace;
      end else if (c == 8'h0A) begin
        s = b40te_pkg::SymNewline;
      end else if (c >= "A" && c <= "Z") begin
        shifted = 1'b1;
        s       = b40te_pkg::sym_t'(c - "A" + 1);
      end else begin
        shifted = 1'b1;
        case (c)
          "(": s = 6'd27;
          "!": s = 6'd28;
          "@": s = 6'd29;
          "#": s = 6'd30;
          ",": s = 6'd31;
          ".": s = 6'd32;
          "?": s = 6'd33;
          "/": s = 6'd34;
          "*": s = 6'd35;
          ")": s = 6'd36;
          "<": s = 6'd37;
          ">": s = 6'd38;
          default: begin
            shifted = 1'b0;
            s       = b40te_pkg::SymUnknown;
          end
        endcase
      end
    endfunction

    // Third symbol closes the word without being stored.
    function bit push(input b40te_pkg::sym_t s, output logic [15:0] w);
      w = '0;
      if (held_count == 2) begin
        w          = weigh(held[0], held[1], s);
        held_count = 0;
        return 1'b1;
      end
      held[held_count] = s;
      held_count++;
      return 1'b0;
    endfunction

    function void take_char(b40te_pkg::char_item_t item);
      bit                     shifted;
      b40te_pkg::sym_t        s;
      logic [15:0]            w;
      logic [15:0]            made [2];
      int                     n;
      b40te_pkg::word_item_t  e;
      n = 0;
      classify(item.char_in, shifted, s);
      if (shifted) begin
        if (push(b40te_pkg::SymShift, w)) begin
          made[n] = w;
          n++;
        end
      end
      if (push(s, w)) begin
        made[n] = w;
        n++;
      end
      if (item.last_char && held_count != 0) begin
        made[n]    = weigh(held[0], (held_count == 2) ? held[1] : b40te_pkg::SymPad,
                           b40te_pkg::SymPad);
        n++;
        held_count = 0;
      end
      for (int i = 0; i < n; i++) begin
        e.packed_word = made[i];
        e.run_end     = (i == n - 1);
        words_due.push_back(e);
      end
    endfunction

    function void check_word(b40te_pkg::word_item_t got);
      b40te_pkg::word_item_t e;
      if (words_due.size() == 0) begin
        report($sformatf("word %0d run_end %0b with none due",
                         got.packed_word, got.run_end));
        return;
      end
      e = words_due.pop_front();
      if (got.packed_word !== e.packed_word) begin
        report($sformatf("packed_word: expected %0d, got %0d", e.packed_word, got.packed_word));
      end
      if (got.run_end !== e.run_end) begin
        report($sformatf("run_end: expected %0b, got %0b (word %0d)",
                         e.run_end, got.run_end, e.packed_word));
      end
    endfunction

    function void check_drained();
      if (words_due.size() != 0) begin
        report($sformatf("%0d words still due at end of run", words_due.size()));
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  char_valid = 1'b0;
  b40te_pkg::char_item_t char_item  = '0;
  logic                  char_stall;
  logic                  word_valid;
  b40te_pkg::word_item_t word_item;
  logic                  word_stall = 1'b0;

  word_predictor tracker;
  int unsigned   quiet_cycles = 0;
  int unsigned   chars_sent   = 0;
  // Idle odds in percent; changed between phases
  int unsigned   char_idle_pct  = 6;
  int unsigned   word_stall_pct = 57;

  // Directed characters: each table region, tilde and NUL, unmatched bytes
  // (high and low), a shifted character closing a word then flushing (two
  // words from one transfer), end of message with nothing left to flush, and
  // characters that produce no word at all.
  logic [7:0] dir_chars [25] = '{"a", "z", "0", "9", " ", 8'h0A, 8'h00, "~", 8'hFF,
                                 "A", "Z", "(", "!", "@", "#", "q", "x", "y", "w",
                                 ",", "?", "<", ">", 8'h80, 8'h7F};
  bit         dir_last  [25] = '{0, 0, 0, 0, 0, 0, 0, 0, 0,
                                 0, 1, 0, 0, 0, 1, 1, 0, 0, 1,
                                 0, 0, 0, 1, 0, 1};

  base40_triplet_encoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_item  (char_item),
    .char_stall (char_stall),
    .word_valid (word_valid),
    .word_item  (word_item),
    .word_stall (word_stall)
  );

  always #6 clk = ~clk;

  // Word side: check every transfer, then pick the stall for the next edge.
  // Values read here are pre-edge, since the block updates through NBAs.
  always @(posedge clk) begin
    if (rst) begin
      word_stall <= 1'b0;
    end else begin
      if (word_valid && !word_stall) begin
        tracker.check_word(word_item);
      end
      word_stall <= ($urandom_range(99) < word_stall_pct);
    end
  end

  // Quiet-cycle counter for the hang detector
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (word_valid && !word_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("base40_triplet_encoder_core verification failed");
    $finish;
  end

  // One character transfer. Valid stays high into the next call unless that
  // call idles first, so it is never dropped and raised in the same step.
  task automatic send_char(input logic [7:0] c, input logic last);
    b40te_pkg::char_item_t item;
    item.char_in   = c;
    item.last_char = last;
    while ($urandom_range(99) < char_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item  <= item;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    tracker.take_char(item);
    chars_sent++;
  endtask

  // Message content: mostly table characters, some arbitrary bytes.
  function automatic logic [7:0] pick_char();
    string       punct;
    int unsigned roll;
    punct = "(!@#,.?/*)<>";
    roll  = $urandom_range(99);
    if (roll < 25)      return 8'("a" + $urandom_range(25));
    else if (roll < 35) return 8'("0" + $urandom_range(9));
    else if (roll < 40) return ($urandom_range(1) != 0) ? 8'h20 : 8'h0A;
    else if (roll < 62) return 8'("A" + $urandom_range(25));
    else if (roll < 80) return punct[$urandom_range(11)];
    else if (roll < 88) return ($urandom_range(1) != 0) ? 8'h7E : 8'h00;
    else                return 8'($urandom_range(255));
  endfunction

  // Well-formed messages end with last_char; about one draw in ten is a single
  // loose byte with a random last_char, which may leave a partial word.
  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned count);
    int unsigned stop;
    int unsigned len;
    char_idle_pct  = idle_pct;
    word_stall_pct = stall_pct;
    stop           = chars_sent + count;
    while (chars_sent < stop) begin
      if ($urandom_range(9) == 0) begin
        send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_char(pick_char(), i == len - 1);
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_chars[i]) begin
      send_char(dir_chars[i], dir_last[i]);
    end

    // Slow consumer, then slow producer, then full rate both ways
    run_phase(6, 57, 500);
    run_phase(57, 6, 500);
    run_phase(0, 0, 525);
    char_valid <= 1'b0;

    // Hang detector covers a word that never shows up
    while (tracker.words_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    tracker.check_drained();

    if (tracker.failures == 0) begin
      $display("base40_triplet_encoder_core verification clean");
    end else begin
      $display("base40_triplet_encoder_core verification failed");
    end
    $finish;
  end

endmodule
